>>> sv/s2c_pkg.sv
package s2c_pkg;

  localparam int CordicStages = 16;
  localparam int AtanEntries  = 24;
  localparam int AngW         = 32;
  localparam int CsW          = 34;   // signed Q30 sine/cosine with growth headroom

  localparam logic signed [CsW-1:0] CordicGain = 34'sd652032874;
  localparam int OutW = 17;
  localparam logic signed [OutW-1:0] OutLimit = 17'sd65535;

  localparam logic [1:0] RegDistMin = 2'd0;
  localparam logic [1:0] RegDistMax = 2'd1;
  localparam logic [1:0] RegElevMin = 2'd2;
  localparam logic [1:0] RegElevMax = 2'd3;

  localparam logic [15:0] DistMinRst = 16'd256;
  localparam logic [15:0] DistMaxRst = 16'd65535;
  localparam logic [15:0] ElevMinRst = 16'd182;
  localparam logic [15:0] ElevMaxRst = 16'd32586;

  function automatic logic signed [AngW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [AngW-1:0] r;
    unique case (idx)
      5'd0:  r = 32'sh20000000;
      5'd1:  r = 32'sh12E4051E;
      5'd2:  r = 32'sh09FB385B;
      5'd3:  r = 32'sh051111D4;
      5'd4:  r = 32'sh028B0D43;
      5'd5:  r = 32'sh0145D7E1;
      5'd6:  r = 32'sh00A2F61E;
      5'd7:  r = 32'sh00517C55;
      5'd8:  r = 32'sh0028BE53;
      5'd9:  r = 32'sh00145F2F;
      5'd10: r = 32'sh000A2F98;
      5'd11: r = 32'sh000517CC;
      5'd12: r = 32'sh00028BE6;
      5'd13: r = 32'sh000145F3;
      5'd14: r = 32'sh0000A2FA;
      5'd15: r = 32'sh0000517D;
      5'd16: r = 32'sh000028BE;
      5'd17: r = 32'sh0000145F;
      5'd18: r = 32'sh00000A30;
      5'd19: r = 32'sh00000518;
      5'd20: r = 32'sh0000028C;
      5'd21: r = 32'sh00000146;
      5'd22: r = 32'sh000000A3;
      5'd23: r = 32'sh00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic signed [CsW-1:0]  x;
    logic signed [CsW-1:0]  y;
    logic signed [AngW-1:0] z;
  } cordic_t;

endpackage

>>> sv/spherical_to_cartesian_clamped.sv
// Orbit-camera pose to cartesian offset, streaming.
// Slave channel s_axis_*: one pose per transaction, tdata = {distance,
// elevation, azimuth} from the low bits (48 bits). Master channel m_axis_*:
// tdata = {pos_z, pos_y, pos_x} from the low bits, 17 bits each, zero padded
// to 56 bits. Config channel cfg_*: cfg_index_i selects dist_min, dist_max,
// elev_min, elev_max (0..3). Write only while idle.
// Pipeline registers, in order from an input transaction to the earliest
// output transaction: clamp, CORDIC seed plus one step per stage, sine/cosine
// capture, angle products, distance scale with rounding and saturation.
// Throughput: one transaction per cycle unless the receiver stalls. The whole
// pipeline moves as one enable; when the receiver stalls with a valid result
// at the output, every stage holds, so nothing is lost or repeated, and
// s_axis_tready drops.
// Reset clears all valid bits and restores the register defaults.
module spherical_to_cartesian_clamped (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // azimuth[15:0], elevation[31:16], distance[47:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // pos_x[16:0], pos_y[33:17], pos_z[50:34], zeros
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int N   = s2c_pkg::CordicStages;
  localparam int Lat = N + 5;
  localparam int CsW = s2c_pkg::CsW;

  logic [15:0] dist_min_q, dist_max_q, elev_min_q, elev_max_q;
  logic        en;
  logic [Lat-1:0] vld_q;

  assign cfg_ready_o = 1'b1;
  // advance whenever the output slot is empty or being drained
  assign en            = !vld_q[Lat-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_min_q <= s2c_pkg::DistMinRst;
      dist_max_q <= s2c_pkg::DistMaxRst;
      elev_min_q <= s2c_pkg::ElevMinRst;
      elev_max_q <= s2c_pkg::ElevMaxRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        s2c_pkg::RegDistMin: dist_min_q <= cfg_data_i;
        s2c_pkg::RegDistMax: dist_max_q <= cfg_data_i;
        s2c_pkg::RegElevMin: elev_min_q <= cfg_data_i;
        s2c_pkg::RegElevMax: elev_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
    end
  end

  // Stage 0: clamp (min test first)
  logic [15:0] az_q, el_q, dist_in, el_in, el_c, d_c;
  assign el_in   = s_axis_tdata[31:16];
  assign dist_in = s_axis_tdata[47:32];
  always_comb begin
    priority if (el_in < elev_min_q) el_c = elev_min_q;
    else if (el_in > elev_max_q)     el_c = elev_max_q;
    else                             el_c = el_in;
    priority if (dist_in < dist_min_q) d_c = dist_min_q;
    else if (dist_in > dist_max_q)     d_c = dist_max_q;
    else                               d_c = dist_in;
  end

  logic [15:0] d_pipe_q [Lat-1];
  always_ff @(posedge clk_i) begin
    if (en) begin
      az_q <= s_axis_tdata[15:0];
      el_q <= el_c;
      d_pipe_q[0] <= d_c;
      for (int k = 1; k < Lat-1; k++) d_pipe_q[k] <= d_pipe_q[k-1];
    end
  end

  // Stages 1..N+1: CORDIC lanes
  logic signed [CsW-1:0] s_az, c_az, s_el, c_el;
  s2c_cordic u_az (.clk_i, .en_i(en), .angle_i(az_q), .sin_o(s_az), .cos_o(c_az));
  s2c_cordic u_el (.clk_i, .en_i(en), .angle_i(el_q), .sin_o(s_el), .cos_o(c_el));

  // d_pipe index aligned with CORDIC output: input at 0, cordic out at N+1
  logic signed [CsW-1:0] c_az_q, s_az_q, s_el_q, c_el_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      c_az_q <= c_az; s_az_q <= s_az; s_el_q <= s_el; c_el_q <= c_el;
    end
  end

  // Stage N+3: sin(el) products rounded to Q30
  logic signed [2*CsW-1:0] px, pz;
  logic signed [CsW-1:0]   fx_q, fz_q, ce_q;
  assign px = c_az_q * s_el_q + (68'sd1 <<< 29);
  assign pz = s_az_q * s_el_q + (68'sd1 <<< 29);
  always_ff @(posedge clk_i) begin
    if (en) begin
      fx_q <= CsW'(px >>> 30);
      fz_q <= CsW'(pz >>> 30);
      ce_q <= c_el_q;
    end
  end

  // Stage N+4: scale by distance, round, saturate
  logic signed [CsW+17:0] mx, my, mz;
  logic signed [CsW-12:0] rx, ry, rz;
  logic [15:0] d_al;
  assign d_al = d_pipe_q[Lat-2];
  assign mx = fx_q * $signed({2'b0, d_al}) + (52'sd1 <<< 29);
  assign my = ce_q * $signed({2'b0, d_al}) + (52'sd1 <<< 29);
  assign mz = fz_q * $signed({2'b0, d_al}) + (52'sd1 <<< 29);
  assign rx = (CsW-11)'(mx >>> 30);
  assign ry = (CsW-11)'(my >>> 30);
  assign rz = (CsW-11)'(mz >>> 30);

  function automatic logic [16:0] sat(input logic signed [CsW-12:0] v);
    if (v > $signed({{(CsW-28){1'b0}}, 17'd65535}))       return 17'd65535;
    else if (v < -$signed({{(CsW-28){1'b0}}, 17'd65535})) return -17'd65535;
    else                                                    return v[16:0];
  endfunction

  logic [16:0] ox_q, oy_q, oz_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ox_q <= sat(rx);
      oy_q <= sat(ry);
      oz_q <= sat(rz);
    end
  end

  assign m_axis_tdata = {5'b0, oz_q, oy_q, ox_q};

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[16:0] != 17'h10000)
    else $error("x out of range");
`endif

endmodule

>>> sv/s2c_cordic.sv
// One pipelined CORDIC lane: a seed register, then one rotation step per register stage.
module s2c_cordic (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [15:0]                   angle_i,
  output logic signed [s2c_pkg::CsW-1:0] sin_o,
  output logic signed [s2c_pkg::CsW-1:0] cos_o
);

  localparam int N = s2c_pkg::CordicStages;

  s2c_pkg::cordic_t stage_q [N+1];
  logic             flip_q  [N+1];
  s2c_pkg::cordic_t stage_d [N+1];
  logic [31:0]      ang_w;
  logic [1:0]       quad;
  logic             flip_in;

  always_comb begin
    ang_w   = {angle_i, 16'h0000};
    quad    = ang_w[31:30];
    flip_in = (quad == 2'd1) || (quad == 2'd2);
    stage_d[0].x = s2c_pkg::CordicGain;
    stage_d[0].y = '0;
    stage_d[0].z = flip_in ? $signed(ang_w + 32'h80000000) : $signed(ang_w);
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [s2c_pkg::CsW-1:0] xs, ys;
    assign xs = stage_q[i].x >>> i;
    assign ys = stage_q[i].y >>> i;
    always_comb begin
      if (!stage_q[i].z[31]) begin
        stage_d[i+1].x = stage_q[i].x - ys;
        stage_d[i+1].y = stage_q[i].y + xs;
        stage_d[i+1].z = stage_q[i].z - s2c_pkg::atan_lut(5'(i));
      end else begin
        stage_d[i+1].x = stage_q[i].x + ys;
        stage_d[i+1].y = stage_q[i].y - xs;
        stage_d[i+1].z = stage_q[i].z + s2c_pkg::atan_lut(5'(i));
      end
    end
  end

  // advance the seed, every rotation step and the quadrant flag together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flip_q[0] <= flip_in;
      for (int k = 0; k <= N; k++) stage_q[k] <= stage_d[k];
      for (int k = 1; k <= N; k++) flip_q[k] <= flip_q[k-1];
    end
  end

  assign cos_o = flip_q[N] ? -stage_q[N].x : stage_q[N].x;
  assign sin_o = flip_q[N] ? -stage_q[N].y : stage_q[N].y;

endmodule
